[design/mcsq_pkg.sv]
package mcsq_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 26;
    localparam int COUNT_W   = 11;
    localparam int TOL_W     = 8;
    localparam int FAIL_W    = 8;
    localparam int RETRY_W   = 4;
    localparam int TOTAL_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 88;
    localparam int TUSER_OUT_W = 4;

    localparam logic [SAMPLE_W-1:0] MIN_INIT = {SAMPLE_W{1'b1}};

    localparam logic [COUNT_W-1:0] NEEDED_RESET  = 11'd32;
    localparam logic [TOL_W-1:0]   TOL_RESET     = 8'd5;
    localparam logic [FAIL_W-1:0]  FAIL_RESET    = 8'd128;
    localparam logic [RETRY_W-1:0] RETRY_RESET   = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDED_COUNT  = 2'd0,
        REG_TOLERANCE     = 2'd1,
        REG_FAILURE_LIMIT = 2'd2,
        REG_RETRY_LIMIT   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_COLLECT  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_ABORT    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CL_NEW_MIN = 2'd0,
        CL_CLOSE   = 2'd1,
        CL_REJECT  = 2'd2,
        CL_RESTART = 2'd3
    } sample_class_t;

    typedef struct packed {
        logic [COUNT_W-1:0] needed_count;
        logic [TOL_W-1:0]   tolerance;
        logic [FAIL_W-1:0]  failure_limit;
        logic [RETRY_W-1:0] retry_limit;
    } cfg_t;

    typedef struct packed {
        status_t             status;
        sample_class_t       sample_class;
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] minimum;
        logic [COUNT_W-1:0]  close_count;
        logic [TOTAL_W-1:0]  rejected_total;
        logic [TOTAL_W-1:0]  restarts_total;
    } result_t;

endpackage

[design/minimum_cluster_sample_qualifier.sv]
// Channel   | Dir | Beat content
// s_*       | in  | tdata[15:0] sample
// m_*       | out | tuser: status, sample_class; tdata: sum, minimum, close_count, totals
// cfg_*     | in  | write enable, register index, write data (no read-back)
//
// One sample per cycle unless output stalls; a beat is registered at input, then at result.
// The state update is a single compare-and-add pass between the input register and
// the result register, so a new beat is taken every cycle while the output drains.
// Reset (rst_n, asynchronous) restores the measurement state, totals and registers.
// A stalled output holds its beat; the input register then fills and s_tready drops.
module minimum_cluster_sample_qualifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mcsq_pkg::TDATA_IN_W-1:0]      s_tdata,  // [15:0] sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [25:0] sum, [41:26] minimum, [52:42] close_count, [68:53] rejected_total,
    // [84:69] restarts_total, [87:85] zero
    output logic [mcsq_pkg::TDATA_OUT_W-1:0]     m_tdata,
    output logic [mcsq_pkg::TUSER_OUT_W-1:0]     m_tuser,  // [1:0] status, [3:2] sample_class
    input  logic                                 cfg_we,
    input  logic [mcsq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcsq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import mcsq_pkg::*;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                out_valid_reg;
    result_t             out_res_reg;
    logic                advance;
    cfg_t                cfg;
    result_t             res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    mcsq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mcsq_update u_update (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (in_sample_reg),
        .cfg    (cfg),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.sample_class, out_res_reg.status};
    assign m_tdata  = {3'b000,
                       out_res_reg.restarts_total,
                       out_res_reg.rejected_total,
                       out_res_reg.close_count,
                       out_res_reg.minimum,
                       out_res_reg.sum};

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_sample_reg)))
        else $error("pending sample lost while output stalled");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result register overwritten before it was taken");

    a_fill_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed sample produced no result beat");

endmodule

[design/mcsq_cfg.sv]
module mcsq_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mcsq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcsq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output mcsq_pkg::cfg_t                    cfg
);
    import mcsq_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.needed_count  <= NEEDED_RESET;
            cfg_reg.tolerance     <= TOL_RESET;
            cfg_reg.failure_limit <= FAIL_RESET;
            cfg_reg.retry_limit   <= RETRY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_NEEDED_COUNT:  cfg_reg.needed_count  <= cfg_wdata[COUNT_W-1:0];
                REG_TOLERANCE:     cfg_reg.tolerance     <= cfg_wdata[TOL_W-1:0];
                REG_FAILURE_LIMIT: cfg_reg.failure_limit <= cfg_wdata[FAIL_W-1:0];
                REG_RETRY_LIMIT:   cfg_reg.retry_limit   <= cfg_wdata[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/mcsq_update.sv]
module mcsq_update (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [mcsq_pkg::SAMPLE_W-1:0]   sample,
    input  mcsq_pkg::cfg_t                  cfg,
    output mcsq_pkg::result_t               res
);
    import mcsq_pkg::*;

    logic [SAMPLE_W-1:0] run_minimum_reg, run_minimum_next;
    logic [COUNT_W-1:0]  run_close_count_reg, run_close_count_next;
    logic [FAIL_W-1:0]   run_failures_reg, run_failures_next;
    logic [RETRY_W-1:0]  run_retries_reg, run_retries_next;
    logic [SUM_W-1:0]    run_sum_reg, run_sum_next;
    logic [TOTAL_W-1:0]  rejected_counter_reg, rejected_counter_next;
    logic [TOTAL_W-1:0]  restart_counter_reg, restart_counter_next;

    logic                is_new_min;
    logic                is_close;
    logic [SAMPLE_W:0]   close_bound;
    logic [FAIL_W-1:0]   failures_inc;
    logic [RETRY_W-1:0]  retries_inc;
    logic                restart;
    logic                abort;
    logic                complete;
    sample_class_t       cls;

    // The bound carries one extra bit so minimum plus tolerance never wraps.
    assign close_bound  = {1'b0, run_minimum_reg} + {{(SAMPLE_W+1-TOL_W){1'b0}}, cfg.tolerance};
    assign is_new_min   = sample < run_minimum_reg;
    assign is_close     = {1'b0, sample} < close_bound;
    assign failures_inc = run_failures_reg + 1'b1;
    assign retries_inc  = run_retries_reg + 1'b1;
    assign restart      = !is_new_min && !is_close && (failures_inc == cfg.failure_limit);
    assign abort        = restart && (retries_inc == cfg.retry_limit);

    // Per-sample update before any end-of-measurement reinitialization.
    logic [SAMPLE_W-1:0] upd_minimum;
    logic [COUNT_W-1:0]  upd_close_count;
    logic [FAIL_W-1:0]   upd_failures;
    logic [RETRY_W-1:0]  upd_retries;
    logic [SUM_W-1:0]    upd_sum;

    always_comb
    begin
        upd_minimum           = run_minimum_reg;
        upd_close_count       = run_close_count_reg;
        upd_failures          = run_failures_reg;
        upd_retries           = run_retries_reg;
        upd_sum               = run_sum_reg;
        rejected_counter_next = rejected_counter_reg;
        restart_counter_next  = restart_counter_reg;
        cls                   = CL_REJECT;
        priority if (is_new_min)
        begin
            upd_minimum     = sample;
            upd_close_count = {{(COUNT_W-1){1'b0}}, 1'b1};
            upd_failures    = '0;
            upd_sum         = {{(SUM_W-SAMPLE_W){1'b0}}, sample};
            cls             = CL_NEW_MIN;
        end
        else if (is_close)
        begin
            upd_sum         = run_sum_reg + {{(SUM_W-SAMPLE_W){1'b0}}, sample};
            upd_close_count = run_close_count_reg + 1'b1;
            upd_failures    = '0;
            cls             = CL_CLOSE;
        end
        else
        begin
            rejected_counter_next = rejected_counter_reg + 1'b1;
            upd_failures          = failures_inc;
            if (restart)
            begin
                cls                  = CL_RESTART;
                upd_retries          = retries_inc;
                restart_counter_next = restart_counter_reg + 1'b1;
                if (!abort)
                begin
                    upd_failures    = '0;
                    upd_minimum     = MIN_INIT;
                    upd_close_count = '0;
                end
            end
        end
    end

    assign complete = !abort && (upd_close_count >= cfg.needed_count);

    always_comb
    begin
        res.sample_class   = cls;
        res.minimum        = upd_minimum;
        res.close_count    = upd_close_count;
        res.rejected_total = rejected_counter_next;
        res.restarts_total = restart_counter_next;
        res.sum            = abort ? '0 : upd_sum;
        priority if (abort)
            res.status = ST_ABORT;
        else if (complete)
            res.status = ST_COMPLETE;
        else
            res.status = ST_COLLECT;
    end

    always_comb
    begin
        if (abort || complete)
        begin
            run_minimum_next     = MIN_INIT;
            run_close_count_next = '0;
            run_failures_next    = '0;
            run_retries_next     = '0;
            run_sum_next         = '0;
        end
        else
        begin
            run_minimum_next     = upd_minimum;
            run_close_count_next = upd_close_count;
            run_failures_next    = upd_failures;
            run_retries_next     = upd_retries;
            run_sum_next         = upd_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_minimum_reg      <= MIN_INIT;
            run_close_count_reg  <= '0;
            run_failures_reg     <= '0;
            run_retries_reg      <= '0;
            run_sum_reg          <= '0;
            rejected_counter_reg <= '0;
            restart_counter_reg  <= '0;
        end
        else if (step)
        begin
            run_minimum_reg      <= run_minimum_next;
            run_close_count_reg  <= run_close_count_next;
            run_failures_reg     <= run_failures_next;
            run_retries_reg      <= run_retries_next;
            run_sum_reg          <= run_sum_next;
            rejected_counter_reg <= rejected_counter_next;
            restart_counter_reg  <= restart_counter_next;
        end
    end

    a_end_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.status != ST_COLLECT) |=>
            (run_close_count_reg == '0 && run_sum_reg == '0 && run_retries_reg == '0
             && run_minimum_reg == MIN_INIT))
        else $error("measurement state not reinitialized after complete or abort");

    a_abort_class: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.status == ST_ABORT) |-> (res.sample_class == CL_RESTART && res.sum == '0))
        else $error("abort reported without restart class or with nonzero sum");

    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.sample_class == CL_RESTART) |=>
            (restart_counter_reg == $past(restart_counter_reg) + 1'b1))
        else $error("restart total did not advance on a restart");

endmodule

[test/minimum_cluster_sample_qualifier_checker.sv]
`timescale 1ns / 1ps
module minimum_cluster_sample_qualifier_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [mcsq_pkg::TDATA_IN_W-1:0]      s_tdata,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [mcsq_pkg::TDATA_OUT_W-1:0]     m_tdata,
    input  logic [mcsq_pkg::TUSER_OUT_W-1:0]     m_tuser,
    input  logic                                 cfg_we,
    input  logic [mcsq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcsq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output int                                   outstanding,
    output int                                   fail_count
);
    import mcsq_pkg::*;

    localparam int MIN_LSB = SUM_W;
    localparam int CNT_LSB = MIN_LSB + SAMPLE_W;
    localparam int REJ_LSB = CNT_LSB + COUNT_W;
    localparam int RST_LSB = REJ_LSB + TOTAL_W;

    // Register copies.
    logic [COUNT_W-1:0]  needed_q;
    logic [TOL_W-1:0]    tol_q;
    logic [FAIL_W-1:0]   fail_limit_q;
    logic [RETRY_W-1:0]  retry_limit_q;

    // Measurement state and running totals.
    logic [SAMPLE_W-1:0] min_q;
    logic [COUNT_W-1:0]  close_q;
    logic [FAIL_W-1:0]   fails_q;
    logic [RETRY_W-1:0]  retries_q;
    logic [SUM_W-1:0]    sum_q;
    logic [TOTAL_W-1:0]  rejected_q;
    logic [TOTAL_W-1:0]  restarts_q;

    result_t expected_results[$];

    initial fail_count = 0;

    task automatic begin_measurement();
        min_q     = MIN_INIT;
        close_q   = '0;
        fails_q   = '0;
        retries_q = '0;
        sum_q     = '0;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        fail_count++;
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic qualify_sample(input logic [SAMPLE_W-1:0] s, output result_t r);
        logic aborted;
        aborted = 1'b0;
        r.status = ST_COLLECT;
        if (s < min_q) begin
            min_q   = s;
            close_q = {{(COUNT_W-1){1'b0}}, 1'b1};
            fails_q = '0;
            sum_q   = {{(SUM_W-SAMPLE_W){1'b0}}, s};
            r.sample_class = CL_NEW_MIN;
        end
        // The bound is formed one bit wider so that it cannot wrap.
        else if ({1'b0, s} < {1'b0, min_q} + {{(SAMPLE_W+1-TOL_W){1'b0}}, tol_q}) begin
            sum_q   = sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, s};
            close_q = close_q + 1'b1;
            fails_q = '0;
            r.sample_class = CL_CLOSE;
        end
        else begin
            rejected_q = rejected_q + 1'b1;
            fails_q    = fails_q + 1'b1;
            r.sample_class = CL_REJECT;
            if (fails_q == fail_limit_q) begin
                r.sample_class = CL_RESTART;
                retries_q  = retries_q + 1'b1;
                restarts_q = restarts_q + 1'b1;
                if (retries_q == retry_limit_q)
                    aborted = 1'b1;
                else begin
                    fails_q = '0;
                    min_q   = MIN_INIT;
                    close_q = '0;
                end
            end
        end
        r.minimum        = min_q;
        r.close_count    = close_q;
        r.rejected_total = rejected_q;
        r.restarts_total = restarts_q;
        if (aborted) begin
            r.status = ST_ABORT;
            r.sum    = '0;
            begin_measurement();
        end
        else begin
            r.sum = sum_q;
            if (close_q >= needed_q) begin
                r.status = ST_COMPLETE;
                begin_measurement();
            end
        end
    endtask

    always @(posedge clk) begin : watch
        result_t oldest;
        result_t fresh;
        if (!rst_n) begin
            needed_q      = NEEDED_RESET;
            tol_q         = TOL_RESET;
            fail_limit_q  = FAIL_RESET;
            retry_limit_q = RETRY_RESET;
            begin_measurement();
            rejected_q = '0;
            restarts_q = '0;
            expected_results.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0)
                    report("unexpected result beat", m_tdata[31:0], 32'd0);
                else begin
                    oldest = expected_results.pop_front();
                    if (m_tuser[1:0] !== oldest.status)
                        report("status", m_tuser[1:0], oldest.status);
                    if (m_tuser[3:2] !== oldest.sample_class)
                        report("sample_class", m_tuser[3:2], oldest.sample_class);
                    if (m_tdata[SUM_W-1:0] !== oldest.sum)
                        report("sum", m_tdata[SUM_W-1:0], oldest.sum);
                    if (m_tdata[MIN_LSB +: SAMPLE_W] !== oldest.minimum)
                        report("minimum", m_tdata[MIN_LSB +: SAMPLE_W], oldest.minimum);
                    if (m_tdata[CNT_LSB +: COUNT_W] !== oldest.close_count)
                        report("close_count", m_tdata[CNT_LSB +: COUNT_W], oldest.close_count);
                    if (m_tdata[REJ_LSB +: TOTAL_W] !== oldest.rejected_total)
                        report("rejected_total", m_tdata[REJ_LSB +: TOTAL_W],
                               oldest.rejected_total);
                    if (m_tdata[RST_LSB +: TOTAL_W] !== oldest.restarts_total)
                        report("restarts_total", m_tdata[RST_LSB +: TOTAL_W],
                               oldest.restarts_total);
                end
            end
            if (s_tvalid && s_tready) begin
                qualify_sample(s_tdata[SAMPLE_W-1:0], fresh);
                expected_results.push_back(fresh);
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_NEEDED_COUNT:  needed_q      = cfg_wdata[COUNT_W-1:0];
                    REG_TOLERANCE:     tol_q         = cfg_wdata[TOL_W-1:0];
                    REG_FAILURE_LIMIT: fail_limit_q  = cfg_wdata[FAIL_W-1:0];
                    REG_RETRY_LIMIT:   retry_limit_q = cfg_wdata[RETRY_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

[test/tb_minimum_cluster_sample_qualifier.sv]
`timescale 1ns / 1ps
module tb_minimum_cluster_sample_qualifier;
    import mcsq_pkg::*;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [TUSER_OUT_W-1:0] m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int outstanding;
    int fail_count;
    int idle_pct  = 0;
    int stall_pct = 0;
    logic [SAMPLE_W-1:0] cluster_base = '0;

    minimum_cluster_sample_qualifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    minimum_cluster_sample_qualifier_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= stall_pct);

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Holds the input until every beat has come out and the pipeline has emptied.
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(input int needed, input int tol, input int fail_lim,
                             input int retry_lim);
        drain();
        write_reg(REG_NEEDED_COUNT, CFG_DATA_W'(needed));
        write_reg(REG_TOLERANCE, CFG_DATA_W'(tol));
        write_reg(REG_FAILURE_LIMIT, CFG_DATA_W'(fail_lim));
        write_reg(REG_RETRY_LIMIT, CFG_DATA_W'(retry_lim));
    endtask

    // Samples cluster just above a moving base, so measurements complete; rej_pct sets
    // the share of far samples that get rejected, beside lower samples and pure noise.
    function automatic logic [SAMPLE_W-1:0] cluster_sample(input int tol, input int rej_pct);
        int pick;
        int v;
        if ($urandom_range(99) < 3)
            cluster_base = SAMPLE_W'($urandom_range(16'hFFFF));
        pick = $urandom_range(99);
        if (pick < 5)
            v = $urandom_range(16'hFFFF);
        else if (pick < 5 + rej_pct)
            v = int'(cluster_base) + tol + int'($urandom_range(300));
        else if (pick < 8 + rej_pct)
        begin
            v = int'(cluster_base) - int'($urandom_range(1, 50));
            if (v < 0)
                v = 0;
            cluster_base = v[SAMPLE_W-1:0];
        end
        else
            v = int'(cluster_base) + ((tol > 0) ? int'($urandom_range(tol - 1)) : 0);
        if (v > 65535)
            v = 65535;
        return v[SAMPLE_W-1:0];
    endfunction

    initial
    begin
        int needed_tab [8] = '{1, 5, 1024, 3, 2047, 8, 0, 12};
        int tol_tab    [8] = '{0, 255, 5, 20, 3, 255, 7, 1};
        int fail_tab   [8] = '{1, 3, 255, 0, 2, 4, 6, 128};
        int retry_tab  [8] = '{1, 15, 0, 2, 3, 1, 4, 8};
        int rej_tab    [8] = '{20, 10, 30, 90, 40, 15, 25, 20};
        int count_tab  [8] = '{100, 100, 100, 300, 100, 100, 100, 100};
        int idle_tab   [4] = '{0, 48, 0, 30};
        int stall_tab  [4] = '{0, 0, 48, 30};
        logic [SAMPLE_W-1:0] first_run [14] = '{
            16'hFFFF, 16'h0000, 16'h00FE, 16'h00FF, 16'hFFFF, 16'h8000, 16'hFFFF,
            16'hFFFF, 16'h1234, 16'h1234, 16'h1235, 16'h1300, 16'h5555, 16'hAAAA};

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Wide tolerance: an all-ones sample is close to an all-ones minimum
        // because the bound does not wrap; then restart, abort and completion.
        configure(4, 255, 2, 2);
        foreach (first_run[i])
            send_sample(first_run[i]);

        // A needed count of zero completes on every sample.
        configure(0, 5, 128, 8);
        send_sample(16'h7FFF);
        send_sample(16'hFFFF);

        // Zero tolerance: an equal sample is rejected and a lower one starts a new minimum.
        configure(32, 0, 3, 1);
        send_sample(16'd100);
        send_sample(16'd100);
        send_sample(16'd99);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);

        for (int p = 0; p < 8; p++)
        begin
            configure(needed_tab[p], tol_tab[p], fail_tab[p], retry_tab[p]);
            idle_pct     = idle_tab[p % 4];
            stall_pct    = stall_tab[p % 4];
            cluster_base = SAMPLE_W'($urandom_range(16'hFFFF));
            for (int i = 0; i < count_tab[p]; i++)
            begin
                send_sample(cluster_sample(tol_tab[p], rej_tab[p]));
                if (p == 1 && i == 50)
                    drain();
            end
        end

        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("minimum_cluster_sample_qualifier verification clean");
        else
            $display("minimum_cluster_sample_qualifier verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("minimum_cluster_sample_qualifier verification failed");
        $finish;
    end

endmodule

[sim.f]
design/mcsq_pkg.sv
design/mcsq_cfg.sv
design/mcsq_update.sv
design/minimum_cluster_sample_qualifier.sv
test/minimum_cluster_sample_qualifier_checker.sv
test/tb_minimum_cluster_sample_qualifier.sv
